// ----- rtl/core/pedestrian_traffic_light_controller_macros.svh -----
// ----------------------------------------------------------------------------
// Assertion macros for the pedestrian crossing controller.
// Each macro samples on clk and is disabled while rst is high.
// ----------------------------------------------------------------------------
`ifndef PEDESTRIAN_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH
`define PEDESTRIAN_TRAFFIC_LIGHT_CONTROLLER_MACROS_SVH

// Consequent must hold in the same cycle as the antecedent.
`define PTLC_ASSERT_SAME(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define PTLC_ASSERT_NEXT(label, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/core/ptlc_pkg.sv -----
// ----------------------------------------------------------------------------
// ptlc_pkg
// Shared types, constants and the walk-cycle lamp table of the controller.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
package ptlc_pkg;

  // Widths of the configuration registers and fields.
  localparam int DARK_W   = 10;
  localparam int TICK_W   = 8;
  localparam int HALF_W   = 6;
  localparam int RUN_W    = 4;
  localparam int CFG_W    = 10;
  localparam int CFG_IDX_W = 2;
  localparam int MODE_W   = 2;

  localparam int LIGHT_BITS_DEFAULT = 10;

  // Register reset values.
  localparam logic [DARK_W-1:0] DARK_RESET  = 10'd700;
  localparam logic [TICK_W-1:0] TICK_RESET  = 8'd50;
  localparam logic [HALF_W-1:0] NIGHT_RESET = 6'd8;
  localparam logic [RUN_W-1:0]  DAY_RESET   = 4'd4;

  // Register indexes on the configuration port.
  localparam logic [CFG_IDX_W-1:0] REG_DARK_THRESHOLD = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TICKS_PER_HALF = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_NIGHT_CONFIRM  = 2'd2;
  localparam logic [CFG_IDX_W-1:0] REG_DAY_CONFIRM    = 2'd3;

  // Mode codes as seen on the result stream.
  localparam logic [MODE_W-1:0] MODE_DAY   = 2'd0;
  localparam logic [MODE_W-1:0] MODE_CHECK = 2'd1;
  localparam logic [MODE_W-1:0] MODE_WALK  = 2'd2;
  localparam logic [MODE_W-1:0] MODE_BLINK = 2'd3;

  // Half-second marks of the walk cycle and the night blink.
  localparam logic [HALF_W-1:0] WALK_YELLOW_START = 6'd4;
  localparam logic [HALF_W-1:0] WALK_RED_START    = 6'd11;
  localparam logic [HALF_W-1:0] WALK_FLASH_START  = 6'd31;
  localparam logic [HALF_W-1:0] WALK_END          = 6'd39;
  localparam logic [HALF_W-1:0] BLINK_LIT         = 6'd1;
  localparam logic [HALF_W-1:0] BLINK_END         = 6'd2;
  localparam logic [HALF_W-1:0] HALF_MAX          = 6'd63;
  localparam logic [RUN_W-1:0]  RUN_MAX           = 4'd15;

  // Control state, one-hot.
  typedef enum logic [3:0] {
    ST_DAY   = 4'b0001,
    ST_CHECK = 4'b0010,
    ST_WALK  = 4'b0100,
    ST_BLINK = 4'b1000
  } state_t;

  // Lamp set, car green in the lowest bit.
  typedef struct packed {
    logic walk_red;
    logic walk_green;
    logic car_red;
    logic car_yellow;
    logic car_green;
  } lamps_t;

  // Configuration register file contents.
  typedef struct packed {
    logic [DARK_W-1:0] dark_threshold;
    logic [TICK_W-1:0] ticks_per_half;
    logic [HALF_W-1:0] night_confirm_halves;
    logic [RUN_W-1:0]  day_confirm_samples;
  } cfg_t;

  localparam lamps_t LAMPS_OFF    = '{default: 1'b0};
  localparam lamps_t LAMPS_DAY    = '{walk_red: 1'b1, car_green: 1'b1, default: 1'b0};
  localparam lamps_t LAMPS_YELLOW = '{car_yellow: 1'b1, default: 1'b0};

  // Lamps of the walk cycle for a given half-second count.
  function automatic lamps_t walk_lamps(input logic [HALF_W-1:0] h);
    lamps_t l;
    l = LAMPS_OFF;
    if (h < WALK_YELLOW_START) begin
      l.car_green = 1'b1;
      l.walk_red  = 1'b1;
    end else if (h < WALK_RED_START) begin
      l.car_yellow = 1'b1;
      l.walk_red   = 1'b1;
    end else if (h < WALK_FLASH_START) begin
      l.car_red    = 1'b1;
      l.walk_green = 1'b1;
    end else begin
      l.car_red  = 1'b1;
      l.walk_red = h[0];
    end
    return l;
  endfunction

  // Mode code shown for a control state.
  function automatic logic [MODE_W-1:0] mode_code(input state_t s);
    logic [MODE_W-1:0] m;
    unique case (s)
      ST_DAY:   m = MODE_DAY;
      ST_CHECK: m = MODE_CHECK;
      ST_WALK:  m = MODE_WALK;
      ST_BLINK: m = MODE_BLINK;
      default:  m = MODE_DAY;
    endcase
    return m;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/core/ptlc_cfg_regs.sv -----
// ----------------------------------------------------------------------------
// ptlc_cfg_regs
// Configuration register file written through a plain write port.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptlc_cfg_regs (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           cfg_we,
  input  wire logic [ptlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptlc_pkg::CFG_W-1:0]     cfg_data,
  output ptlc_pkg::cfg_t                      cfg
);
  import ptlc_pkg::*;

  // Register writes; every index in range maps to a register.
  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.dark_threshold       <= DARK_RESET;
      cfg.ticks_per_half       <= TICK_RESET;
      cfg.night_confirm_halves <= NIGHT_RESET;
      cfg.day_confirm_samples  <= DAY_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        REG_DARK_THRESHOLD: cfg.dark_threshold       <= cfg_data[DARK_W-1:0];
        REG_TICKS_PER_HALF: cfg.ticks_per_half       <= cfg_data[TICK_W-1:0];
        REG_NIGHT_CONFIRM:  cfg.night_confirm_halves <= cfg_data[HALF_W-1:0];
        REG_DAY_CONFIRM:    cfg.day_confirm_samples  <= cfg_data[RUN_W-1:0];
        default: ;
      endcase
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ptlc_in_stage.sv -----
// ----------------------------------------------------------------------------
// ptlc_in_stage
// Input register: holds one tick sample until the control stage takes it.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptlc_in_stage #(
  parameter int LIGHT_BITS = ptlc_pkg::LIGHT_BITS_DEFAULT
) (
  input  wire logic                  clk,
  input  wire logic                  rst,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic                  in_button,
  input  wire logic [LIGHT_BITS-1:0] in_light,
  output logic                       hold_valid,
  input  wire logic                  hold_take,
  output logic                       hold_button,
  output logic [LIGHT_BITS-1:0]      hold_light
);
  import ptlc_pkg::*;

  // Room for a new sample when empty or when the held one leaves this cycle.
  assign in_ready = !hold_valid || hold_take;

  always_ff @(posedge clk) begin
    if (rst) begin
      hold_valid <= 1'b0;
    end else if (in_ready) begin
      hold_valid <= in_valid;
    end
  end

  // Payload, loaded on each accepted transaction.
  always_ff @(posedge clk) begin
    if (in_valid && in_ready) begin
      hold_button <= in_button;
      hold_light  <= in_light;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/core/ptlc_ctrl.sv -----
// ----------------------------------------------------------------------------
// ptlc_ctrl
// Prescaler, mode state machine and the result register.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module ptlc_ctrl #(
  parameter int LIGHT_BITS = ptlc_pkg::LIGHT_BITS_DEFAULT
) (
  input  wire logic                        clk,
  input  wire logic                        rst,
  input  wire ptlc_pkg::cfg_t              cfg,
  input  wire logic                        hold_valid,
  output logic                             hold_take,
  input  wire logic                        hold_button,
  input  wire logic [LIGHT_BITS-1:0]       hold_light,
  output logic                             out_valid,
  input  wire logic                        out_ready,
  output ptlc_pkg::lamps_t                 out_lamps,
  output logic [ptlc_pkg::MODE_W-1:0]      out_mode
);
  import ptlc_pkg::*;
`include "pedestrian_traffic_light_controller_macros.svh"

  localparam int CMP_W = (LIGHT_BITS > DARK_W) ? LIGHT_BITS : DARK_W;

  state_t            state, state_next;
  logic [TICK_W-1:0] prescale_count, prescale_next, prescale_inc;
  logic [HALF_W-1:0] half_count, half_next, half_tick;
  logic              request_latch, request_next, request_set;
  logic [RUN_W-1:0]  daylight_run, daylight_next, run_inc;
  lamps_t            lamps_next;
  logic              dark, bright;

  // The held sample moves on when the result register is free or drains.
  assign hold_take = hold_valid && (!out_valid || out_ready);

  // Light comparison against the threshold at a common width.
  assign dark   = CMP_W'(hold_light) > CMP_W'(cfg.dark_threshold);
  assign bright = CMP_W'(hold_light) < CMP_W'(cfg.dark_threshold);

  // Prescaler runs first; the mode logic sees the stepped half count.
  always_comb begin
    prescale_inc = prescale_count + 1'b1;
    if (prescale_inc >= cfg.ticks_per_half) begin
      prescale_next = '0;
      half_tick     = (half_count == HALF_MAX) ? half_count : half_count + 1'b1;
    end else begin
      prescale_next = prescale_inc;
      half_tick     = half_count;
    end
  end

  // Mode logic for one tick.
  always_comb begin
    state_next    = state;
    half_next     = half_tick;
    request_next  = request_latch;
    daylight_next = daylight_run;
    lamps_next    = LAMPS_DAY;
    request_set   = request_latch | hold_button;
    run_inc       = '0;
    unique case (state)
      ST_DAY: begin
        lamps_next   = LAMPS_DAY;
        request_next = request_set;
        if (dark) begin
          state_next = ST_CHECK;
          half_next  = '0;
        end else if (request_set) begin
          state_next   = ST_WALK;
          half_next    = '0;
          request_next = 1'b0;
        end
      end
      ST_CHECK: begin
        lamps_next = LAMPS_DAY;
        if (half_tick >= cfg.night_confirm_halves) begin
          state_next    = ST_BLINK;
          half_next     = '0;
          daylight_next = '0;
          lamps_next    = LAMPS_OFF;
        end else begin
          request_next = request_set;
          if (request_set || bright) begin
            state_next = ST_DAY;
          end
        end
      end
      ST_WALK: begin
        if (half_tick >= WALK_END) begin
          state_next   = ST_DAY;
          request_next = 1'b0;
          lamps_next   = LAMPS_DAY;
        end else begin
          lamps_next = walk_lamps(half_tick);
        end
      end
      ST_BLINK: begin
        if (half_tick >= BLINK_END) begin
          half_next = '0;
          if (bright) begin
            run_inc = (daylight_run == RUN_MAX) ? daylight_run : daylight_run + 1'b1;
          end
          daylight_next = run_inc;
          lamps_next    = LAMPS_OFF;
          if (run_inc >= cfg.day_confirm_samples) begin
            state_next   = ST_DAY;
            request_next = 1'b0;
            lamps_next   = LAMPS_DAY;
          end
        end else begin
          lamps_next = (half_tick >= BLINK_LIT) ? LAMPS_YELLOW : LAMPS_OFF;
        end
      end
      default: begin
        state_next = ST_DAY;
      end
    endcase
  end

  // State registers advance once per item taken.
  always_ff @(posedge clk) begin
    if (rst) begin
      state          <= ST_DAY;
      prescale_count <= '0;
      half_count     <= '0;
      request_latch  <= 1'b0;
      daylight_run   <= '0;
    end else if (hold_take) begin
      state          <= state_next;
      prescale_count <= prescale_next;
      half_count     <= half_next;
      request_latch  <= request_next;
      daylight_run   <= daylight_next;
    end
  end

  // Result register valid flag.
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (hold_take) begin
      out_valid <= 1'b1;
    end else if (out_ready) begin
      out_valid <= 1'b0;
    end
  end

  // Result payload.
  always_ff @(posedge clk) begin
    if (hold_take) begin
      out_lamps <= lamps_next;
      out_mode  <= mode_code(state_next);
    end
  end

  // Walk green is only ever shown against a red car light.
  `PTLC_ASSERT_SAME(a_walk_safe, out_valid && out_lamps.walk_green, out_lamps.car_red, "walk green without car red")
  // Night blink never lights car green or car red.
  `PTLC_ASSERT_SAME(a_blink_lamps, out_valid && out_mode == MODE_BLINK, !out_lamps.car_green && !out_lamps.car_red, "blink mode with green or red lit")
  // The shown mode tracks the state register.
  `PTLC_ASSERT_SAME(a_mode_track, out_valid, out_mode == mode_code(state), "result mode differs from state")
  // A walk cycle only ends back in day mode.
  `PTLC_ASSERT_NEXT(a_walk_exit, state == ST_WALK, state == ST_WALK || state == ST_DAY, "walk cycle left to a mode other than day")

endmodule
`default_nettype wire

// ----- rtl/core/pedestrian_traffic_light_controller.sv -----
// ----------------------------------------------------------------------------
// pedestrian_traffic_light_controller
// Pedestrian crossing light controller driven by one sample per 10 ms tick.
// ----------------------------------------------------------------------------
//  Channel   Direction  Contents
//  s_axis    in         button, light_level (one tick sample)
//  m_axis    out        car/walk lamps and mode after the tick
//  cfg       in         register write: index, data
//
// Each sample passes an input register and the control logic into the
// result register; one sample is taken every cycle unless the result stalls.
// The state update loop (prescaler, half count, mode) allows this rate. A
// stalled result holds the result register, which then holds the input
// register. Reset is synchronous; no clearing pass follows.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
module pedestrian_traffic_light_controller #(
  parameter int LIGHT_BITS = ptlc_pkg::LIGHT_BITS_DEFAULT
) (
  input  wire logic                           clk,
  input  wire logic                           rst,
  input  wire logic                           s_tvalid,
  output logic                                s_tready,
  // [0] button, [LIGHT_BITS:1] light_level, zero padding above
  input  wire logic [((LIGHT_BITS+8)/8)*8-1:0] s_tdata,
  output logic                                m_tvalid,
  input  wire logic                           m_tready,
  // [0] car_green, [1] car_yellow, [2] car_red, [3] walk_green,
  // [4] walk_red, [6:5] mode, [7] zero
  output logic [7:0]                          m_tdata,
  input  wire logic                           cfg_we,
  input  wire logic [ptlc_pkg::CFG_IDX_W-1:0] cfg_index,
  input  wire logic [ptlc_pkg::CFG_W-1:0]     cfg_data
);
  import ptlc_pkg::*;

  cfg_t                  cfg;
  logic                  hold_valid, hold_take, hold_button;
  logic [LIGHT_BITS-1:0] hold_light;
  lamps_t                out_lamps;
  logic [MODE_W-1:0]     out_mode;

  // Configuration registers.
  ptlc_cfg_regs u_cfg (
    .clk       (clk),
    .rst       (rst),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .cfg       (cfg)
  );

  // Input register.
  ptlc_in_stage #(.LIGHT_BITS(LIGHT_BITS)) u_in (
    .clk         (clk),
    .rst         (rst),
    .in_valid    (s_tvalid),
    .in_ready    (s_tready),
    .in_button   (s_tdata[0]),
    .in_light    (s_tdata[LIGHT_BITS:1]),
    .hold_valid  (hold_valid),
    .hold_take   (hold_take),
    .hold_button (hold_button),
    .hold_light  (hold_light)
  );

  // Control logic and result register.
  ptlc_ctrl #(.LIGHT_BITS(LIGHT_BITS)) u_ctrl (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .hold_valid  (hold_valid),
    .hold_take   (hold_take),
    .hold_button (hold_button),
    .hold_light  (hold_light),
    .out_valid   (m_tvalid),
    .out_ready   (m_tready),
    .out_lamps   (out_lamps),
    .out_mode    (out_mode)
  );

  // Result packing.
  assign m_tdata = {1'b0, out_mode, out_lamps};

endmodule
`default_nettype wire

// ----- sim/pedestrian_traffic_light_controller_test.sv -----
// ----------------------------------------------------------------------------
// pedestrian_traffic_light_controller_test
// Drives tick samples into the crossing controller and checks every lamp set
// and mode it returns against a typed result or a cycle-free model of the
// controller that runs on each accepted transaction. A short table of directed
// ticks comes first, then phases of random day, dark, threshold and noise runs
// under several register settings, with random idle bursts on both streams.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
module pedestrian_traffic_light_controller_test;
  import ptlc_pkg::*;

  localparam int LIGHT_W        = 10;
  localparam int S_W            = ((LIGHT_W + 8) / 8) * 8;
  localparam int LIGHT_MAX      = (1 << LIGHT_W) - 1;
  localparam int PHASE_COUNT    = 8;
  localparam int PHASE_ITEMS    = 173;
  localparam int LONG_HOLD      = 40;
  localparam int WATCHDOG_LIMIT = 1000;
  localparam int DRAIN_CYCLES   = 4;

  // One result of the controller: lamp set and mode.
  typedef struct packed {
    lamps_t            lamps;
    logic [MODE_W-1:0] mode;
  } light_state_t;

  // One directed tick, with the result typed in where it is obvious.
  typedef struct {
    logic               button;
    logic [LIGHT_W-1:0] level;
    bit                 typed;
    light_state_t       result;
  } tick_row_t;

  logic               clk = 1'b0;
  logic               rst = 1'b1;
  logic               s_tvalid = 1'b0;
  logic               s_tready;
  logic [S_W-1:0]     s_tdata = '0;
  logic               m_tvalid;
  logic               m_tready = 1'b0;
  logic [7:0]         m_tdata;
  logic               cfg_we = 1'b0;
  logic [CFG_IDX_W-1:0] cfg_index = REG_DARK_THRESHOLD;
  logic [CFG_W-1:0]   cfg_data = '0;

  // Model state and register copies.
  cfg_t               active_cfg;
  logic [MODE_W-1:0]  pr_mode;
  logic [TICK_W-1:0]  pr_prescale;
  logic [HALF_W-1:0]  pr_half;
  logic               pr_latch;
  logic [RUN_W-1:0]   pr_day_run;
  lamps_t             pr_lamps;

  light_state_t       pending_lights[$];
  int                 mismatch_count = 0;
  int                 quiet_cycles = 0;
  int                 rx_hold = 0;
  bit                 hold_request = 1'b0;
  bit                 no_idle = 1'b0;

  // Receiver-side locals.
  light_state_t       got_state;
  light_state_t       want_state;
  logic [4:0]         got_lamps;
  logic [4:0]         want_lamps;

  string lamp_names [5] = '{"car_green", "car_yellow", "car_red", "walk_green", "walk_red"};

  // Directed ticks under the reset settings (threshold 700, 50 ticks per half).
  tick_row_t directed_rows [13] = '{
    '{1'b0, 10'd0,    1'b1, '{LAMPS_DAY, MODE_DAY}},
    '{1'b0, 10'd700,  1'b1, '{LAMPS_DAY, MODE_DAY}},
    '{1'b0, 10'd1023, 1'b1, '{LAMPS_DAY, MODE_CHECK}},
    '{1'b0, 10'd700,  1'b1, '{LAMPS_DAY, MODE_CHECK}},
    '{1'b0, 10'd699,  1'b1, '{LAMPS_DAY, MODE_DAY}},
    '{1'b0, 10'd701,  1'b1, '{LAMPS_DAY, MODE_CHECK}},
    '{1'b1, 10'd1023, 1'b1, '{LAMPS_DAY, MODE_DAY}},
    '{1'b0, 10'd0,    1'b1, '{LAMPS_DAY, MODE_WALK}},
    '{1'b1, 10'd1023, 1'b1, '{LAMPS_DAY, MODE_WALK}},
    '{1'b0, 10'd0,    1'b0, '{LAMPS_OFF, MODE_DAY}},
    '{1'b1, 10'd512,  1'b0, '{LAMPS_OFF, MODE_DAY}},
    '{1'b0, 10'd1023, 1'b0, '{LAMPS_OFF, MODE_DAY}},
    '{1'b1, 10'd0,    1'b0, '{LAMPS_OFF, MODE_DAY}}
  };

  pedestrian_traffic_light_controller #(
    .LIGHT_BITS(LIGHT_W)
  ) dut (
    .clk      (clk),
    .rst      (rst),
    .s_tvalid (s_tvalid),
    .s_tready (s_tready),
    .s_tdata  (s_tdata),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data)
  );

  // 10 ns clock.
  always begin
    #5 clk = 1'b1;
    #5 clk = 1'b0;
  end

  // Prints one mismatch line and counts it.
  task automatic report_mismatch(input string msg);
    $display("[%0t ns] %s", $time, msg);
    mismatch_count++;
  endtask

  // Puts the model into its reset state with the reset register values.
  function automatic void reset_light_model();
    active_cfg  = '{dark_threshold: DARK_RESET, ticks_per_half: TICK_RESET,
                    night_confirm_halves: NIGHT_RESET, day_confirm_samples: DAY_RESET};
    pr_mode     = MODE_DAY;
    pr_prescale = '0;
    pr_half     = '0;
    pr_latch    = 1'b0;
    pr_day_run  = '0;
    pr_lamps    = LAMPS_DAY;
  endfunction

  // Advances the model by one tick and returns the lamps and mode after it.
  function automatic light_state_t advance_tick(input logic button,
                                                input logic [LIGHT_W-1:0] level);
    logic       dark;
    logic       bright;
    logic [8:0] next_count;
    dark   = level > active_cfg.dark_threshold;
    bright = level < active_cfg.dark_threshold;

    // The prescaler runs first; the mode logic sees the new half count.
    next_count = {1'b0, pr_prescale} + 9'd1;
    if (next_count[TICK_W-1:0] >= active_cfg.ticks_per_half) begin
      pr_prescale = '0;
      if (pr_half < HALF_MAX) pr_half = pr_half + 1'b1;
    end else begin
      pr_prescale = next_count[TICK_W-1:0];
    end

    case (pr_mode)
      MODE_DAY: begin
        pr_lamps = LAMPS_DAY;
        pr_latch = pr_latch | button;
        if (dark) begin
          pr_mode = MODE_CHECK;
          pr_half = '0;
        end else if (pr_latch) begin
          pr_mode  = MODE_WALK;
          pr_half  = '0;
          pr_latch = 1'b0;
        end
      end
      MODE_CHECK: begin
        pr_lamps = LAMPS_DAY;
        if (pr_half >= active_cfg.night_confirm_halves) begin
          pr_mode    = MODE_BLINK;
          pr_half    = '0;
          pr_day_run = '0;
          pr_lamps   = LAMPS_OFF;
        end else begin
          pr_latch = pr_latch | button;
          if (pr_latch || bright) pr_mode = MODE_DAY;
        end
      end
      MODE_WALK: begin
        if (pr_half >= WALK_END) begin
          pr_mode  = MODE_DAY;
          pr_latch = 1'b0;
          pr_lamps = LAMPS_DAY;
        end else begin
          pr_lamps = LAMPS_OFF;
          if (pr_half < WALK_YELLOW_START) begin
            pr_lamps.car_green = 1'b1;
            pr_lamps.walk_red  = 1'b1;
          end else if (pr_half < WALK_RED_START) begin
            pr_lamps.car_yellow = 1'b1;
            pr_lamps.walk_red   = 1'b1;
          end else if (pr_half < WALK_FLASH_START) begin
            pr_lamps.car_red    = 1'b1;
            pr_lamps.walk_green = 1'b1;
          end else begin
            // Walk red flashes: lit on odd half counts.
            pr_lamps.car_red  = 1'b1;
            pr_lamps.walk_red = pr_half[0];
          end
        end
      end
      default: begin
        if (pr_half >= BLINK_END) begin
          // End of one blink: take the daylight sample and restart.
          pr_lamps = LAMPS_OFF;
          pr_half  = '0;
          if (bright) begin
            if (pr_day_run < RUN_MAX) pr_day_run = pr_day_run + 1'b1;
          end else begin
            pr_day_run = '0;
          end
          if (pr_day_run >= active_cfg.day_confirm_samples) begin
            pr_mode  = MODE_DAY;
            pr_latch = 1'b0;
            pr_lamps = LAMPS_DAY;
          end
        end else begin
          pr_lamps = (pr_half >= BLINK_LIT) ? LAMPS_YELLOW : LAMPS_OFF;
        end
      end
    endcase
    return '{pr_lamps, pr_mode};
  endfunction

  // Offers one tick, waits for the transaction, and queues its expected result.
  task automatic send_tick(input logic button, input logic [LIGHT_W-1:0] level,
                           input bit typed, input light_state_t typed_result);
    light_state_t predicted;
    if (!no_idle && $urandom_range(5, 0) == 0) begin
      s_tvalid <= 1'b0;
      repeat ($urandom_range(3, 1)) @(posedge clk);
    end
    s_tvalid <= 1'b1;
    s_tdata  <= {{(S_W - LIGHT_W - 1){1'b0}}, level, button};
    @(posedge clk);
    while (!s_tready) @(posedge clk);
    predicted = advance_tick(button, level);
    pending_lights.push_back(typed ? typed_result : predicted);
  endtask

  // Waits until every expected result has come, then lets the pipeline settle.
  task automatic wait_drained();
    while (pending_lights.size() != 0) @(posedge clk);
    repeat (DRAIN_CYCLES) @(posedge clk);
  endtask

  // Writes one register on the configuration port and in the model.
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx, input logic [CFG_W-1:0] value);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= value;
    @(posedge clk);
    case (idx)
      REG_DARK_THRESHOLD: active_cfg.dark_threshold       = value[DARK_W-1:0];
      REG_TICKS_PER_HALF: active_cfg.ticks_per_half       = value[TICK_W-1:0];
      REG_NIGHT_CONFIRM:  active_cfg.night_confirm_halves = value[HALF_W-1:0];
      default:            active_cfg.day_confirm_samples  = value[RUN_W-1:0];
    endcase
  endtask

  // A sample that reads as daylight under the current threshold, where one exists.
  function automatic logic [LIGHT_W-1:0] bright_level();
    int thr;
    thr = active_cfg.dark_threshold;
    return (thr == 0) ? '0 : LIGHT_W'($urandom_range(thr - 1, 0));
  endfunction

  // A sample that reads as darkness under the current threshold, where one exists.
  function automatic logic [LIGHT_W-1:0] dark_level();
    int thr;
    thr = active_cfg.dark_threshold;
    return (thr == LIGHT_MAX) ? LIGHT_W'(LIGHT_MAX) : LIGHT_W'($urandom_range(LIGHT_MAX, thr + 1));
  endfunction

  // One phase: settle, load the registers, then random runs of ticks.
  task automatic run_phase(input int phase, input cfg_t settings, input int n_items);
    int           sent;
    int           kind;
    int           run_len;
    logic         button;
    logic [LIGHT_W-1:0] level;
    sent = 0;
    s_tvalid <= 1'b0;
    wait_drained();
    write_reg(REG_DARK_THRESHOLD, CFG_W'(settings.dark_threshold));
    write_reg(REG_TICKS_PER_HALF, CFG_W'(settings.ticks_per_half));
    write_reg(REG_NIGHT_CONFIRM,  CFG_W'(settings.night_confirm_halves));
    write_reg(REG_DAY_CONFIRM,    CFG_W'(settings.day_confirm_samples));
    cfg_we <= 1'b0;
    no_idle = (phase == PHASE_COUNT - 1);

    while (sent < n_items) begin
      kind    = $urandom_range(9, 0);
      run_len = $urandom_range(48, 4);
      for (int k = 0; k < run_len && sent < n_items; k++) begin
        case (kind)
          // Daylight with an occasional button press.
          0, 1, 2, 3: begin
            level  = bright_level();
            button = ($urandom_range(24, 0) == 0);
          end
          // Darkness, long enough to confirm night at short settings.
          4, 5, 6: begin
            level  = dark_level();
            button = ($urandom_range(39, 0) == 0);
          end
          // Samples right at the threshold.
          7: begin
            level  = active_cfg.dark_threshold;
            button = 1'($urandom_range(1, 0));
          end
          default: begin
            level  = LIGHT_W'($urandom_range(LIGHT_MAX, 0));
            button = 1'($urandom_range(1, 0));
          end
        endcase
        send_tick(button, level, 1'b0, '0);
        sent++;
        // Long receiver stall while ticks keep coming.
        if (phase == 4 && sent == 60) hold_request = 1'b1;
        // Sender pause until everything in flight has come back.
        if (phase == 5 && sent == 80) begin
          s_tvalid <= 1'b0;
          wait_drained();
        end
      end
    end
  endtask

  // Receiver: checks each result transaction and idles in random bursts.
  always @(posedge clk) begin
    if (!rst && m_tvalid && m_tready) begin
      if (pending_lights.size() == 0) begin
        report_mismatch($sformatf("result %02h arrived with nothing expected", m_tdata));
      end else begin
        want_state = pending_lights.pop_front();
        // Lamps sit in the low bits of tdata, the mode above them.
        got_state  = {m_tdata[4:0], m_tdata[6:5]};
        got_lamps  = got_state.lamps;
        want_lamps = want_state.lamps;
        for (int i = 0; i < 5; i++) begin
          if (got_lamps[i] !== want_lamps[i])
            report_mismatch($sformatf("%s: got %0b, expected %0b",
                                      lamp_names[i], got_lamps[i], want_lamps[i]));
        end
        if (got_state.mode !== want_state.mode)
          report_mismatch($sformatf("mode: got %0d, expected %0d",
                                    got_state.mode, want_state.mode));
      end
    end

    if (hold_request) begin
      hold_request = 1'b0;
      rx_hold      = LONG_HOLD;
    end else if (rx_hold == 0 && !no_idle && $urandom_range(5, 0) == 0) begin
      rx_hold = $urandom_range(3, 1);
    end
    if (rx_hold > 0) begin
      rx_hold--;
      m_tready <= 1'b0;
    end else begin
      m_tready <= 1'b1;
    end
  end

  // Watchdog: ends the run when nothing moves for too long.
  always @(posedge clk) begin
    if ((s_tvalid && s_tready) || (m_tvalid && m_tready) || cfg_we) quiet_cycles <= 0;
    else quiet_cycles <= quiet_cycles + 1;
    if (quiet_cycles >= WATCHDOG_LIMIT) begin
      $display("Mismatches found");
      $finish;
    end
  end

  // Main sequence.
  initial begin
    cfg_t phase_cfg [PHASE_COUNT];
    reset_light_model();

    // Fixed settings first, including both extremes, then random short ones.
    phase_cfg[0] = '{dark_threshold: 10'd700,  ticks_per_half: 8'd1,
                     night_confirm_halves: 6'd8,  day_confirm_samples: 4'd4};
    phase_cfg[1] = '{dark_threshold: 10'd0,    ticks_per_half: 8'd0,
                     night_confirm_halves: 6'd0,  day_confirm_samples: 4'd0};
    phase_cfg[2] = '{dark_threshold: 10'd1023, ticks_per_half: 8'd255,
                     night_confirm_halves: 6'd63, day_confirm_samples: 4'd15};
    phase_cfg[3] = '{dark_threshold: 10'd512,  ticks_per_half: 8'd1,
                     night_confirm_halves: 6'd63, day_confirm_samples: 4'd15};
    for (int p = 4; p < PHASE_COUNT; p++) begin
      phase_cfg[p].dark_threshold       = DARK_W'($urandom_range(1022, 1));
      phase_cfg[p].ticks_per_half       = TICK_W'($urandom_range(4, 1));
      phase_cfg[p].night_confirm_halves = HALF_W'($urandom_range(10, 1));
      phase_cfg[p].day_confirm_samples  = RUN_W'($urandom_range(5, 1));
    end

    repeat (3) @(posedge clk);
    rst <= 1'b0;

    // Directed ticks under the reset register values.
    foreach (directed_rows[r])
      send_tick(directed_rows[r].button, directed_rows[r].level,
                directed_rows[r].typed, directed_rows[r].result);

    for (int p = 0; p < PHASE_COUNT; p++)
      run_phase(p, phase_cfg[p], PHASE_ITEMS);

    s_tvalid <= 1'b0;
    wait_drained();
    if (mismatch_count == 0) begin
      $display("No mismatches found");
    end else begin
      $display("Mismatches found");
    end
    $finish;
  end

endmodule
